// File: rtl/awac_pkg.sv
// ----------------------------------------------------------------------------
// awac_pkg - shared types and constants for the angle wrap and arc check
// Widths, the fixed-point 2pi constant and the per-cell subtrahends.
// ----------------------------------------------------------------------------
package awac_pkg;

    localparam int ANGLE_W = 32;
    localparam int MAG_W   = ANGLE_W;
    localparam int RES_W   = 27;
    localparam int TOL_W   = 27;
    localparam int IDX_W   = 2;
    localparam int N_CELLS = 5;

    // round(2pi * 2^24)
    localparam logic [RES_W-1:0] TWO_PI = 27'd105414357;

    localparam logic [TOL_W-1:0] TOL_RESET = 27'd17;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_REGION_START   = 2'd0;
    localparam logic [IDX_W-1:0] REG_REGION_END     = 2'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_TOLERANCE = 2'd2;

    // one item in flight: magnitudes and signs of the angle and both bounds, and last
    typedef struct packed {
        logic [MAG_W-1:0] a_mag;
        logic [MAG_W-1:0] s_mag;
        logic [MAG_W-1:0] e_mag;
        logic             a_neg;
        logic             s_neg;
        logic             e_neg;
        logic             last;
    } lane_t;

    // cell 0 takes off 16 x 2pi, the final cell 1 x 2pi
    function automatic logic [MAG_W-1:0] cell_mult(input int idx);
        cell_mult = MAG_W'(TWO_PI) << (N_CELLS - 1 - idx);
    endfunction

endpackage

// File: rtl/awac_cell.sv
// ----------------------------------------------------------------------------
// awac_cell - one conditional-subtract cell of the reduction chain
// Takes one multiple of 2pi off each of the three lanes when it fits.
// ----------------------------------------------------------------------------
module awac_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [awac_pkg::MAG_W-1:0] mult,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  awac_pkg::lane_t           in_lane,
    output logic                      out_valid,
    input  logic                      out_ready,
    output awac_pkg::lane_t           out_lane
);

    logic            valid_reg;
    logic            valid_next;
    awac_pkg::lane_t lane_reg;
    awac_pkg::lane_t lane_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        lane_next = in_lane;
        if (in_lane.a_mag >= mult)
        begin
            lane_next.a_mag = in_lane.a_mag - mult;
        end
        if (in_lane.s_mag >= mult)
        begin
            lane_next.s_mag = in_lane.s_mag - mult;
        end
        if (in_lane.e_mag >= mult)
        begin
            lane_next.e_mag = in_lane.e_mag - mult;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

// File: rtl/awac_tail.sv
// ----------------------------------------------------------------------------
// awac_tail - sign fix-up, zero snap, arc test and run verdict
// Two stages: finish the wrap of all three lanes, then test and register.
// ----------------------------------------------------------------------------
module awac_tail
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [awac_pkg::TOL_W-1:0] tol,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  awac_pkg::lane_t            in_lane,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [awac_pkg::RES_W-1:0] wrapped_angle,
    output logic                       angle_in_region,
    output logic                       all_in_region,
    output logic                       run_end
);

    // remainder below 2pi; a negative input mirrors to 2pi - r, then snap
    function automatic logic [awac_pkg::RES_W-1:0] finish_wrap
    (
        input logic [awac_pkg::MAG_W-1:0] r,
        input logic                       neg,
        input logic [awac_pkg::TOL_W-1:0] t
    );
        logic [awac_pkg::RES_W-1:0] rr;
        logic [awac_pkg::RES_W-1:0] f;
        rr = r[awac_pkg::RES_W-1:0];
        f  = (neg && (rr != '0)) ? (awac_pkg::TWO_PI - rr) : rr;
        finish_wrap = (f < t) ? '0 : f;
    endfunction

    // finish stage
    logic                       fin_valid_reg;
    logic                       fin_valid_next;
    logic                       fin_ready;
    logic [awac_pkg::RES_W-1:0] fin_a_reg;
    logic [awac_pkg::RES_W-1:0] fin_s_reg;
    logic [awac_pkg::RES_W-1:0] fin_e_reg;
    logic                       fin_last_reg;

    // output stage
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_ready;
    logic                       load_out;
    logic [awac_pkg::RES_W-1:0] wrapped_reg;
    logic                       inside_reg;
    logic                       inside_next;
    logic                       all_reg;
    logic                       all_next;
    logic                       run_end_reg;
    logic                       run_ok_reg;
    logic                       run_ok_next;
    logic [awac_pkg::RES_W-1:0] diff;

    assign out_ready      = !out_valid_reg || !out_stall;
    assign fin_ready      = !fin_valid_reg || out_ready;
    assign in_ready       = fin_ready;
    assign fin_valid_next = fin_ready ? in_valid : fin_valid_reg;
    assign load_out       = out_ready && fin_valid_reg;
    assign out_valid_next = out_ready ? fin_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (fin_ready && in_valid)
        begin
            fin_a_reg    <= finish_wrap(in_lane.a_mag, in_lane.a_neg, tol);
            fin_s_reg    <= finish_wrap(in_lane.s_mag, in_lane.s_neg, tol);
            fin_e_reg    <= finish_wrap(in_lane.e_mag, in_lane.e_neg, tol);
            fin_last_reg <= in_lane.last;
        end
    end

    always_comb
    begin
        diff = (fin_s_reg > fin_e_reg) ? (fin_s_reg - fin_e_reg) : (fin_e_reg - fin_s_reg);
        if ((fin_s_reg == fin_e_reg) || (diff < tol))
        begin
            inside_next = 1'b1;     // full circle
        end
        else if (fin_s_reg < fin_e_reg)
        begin
            inside_next = (fin_a_reg >= fin_s_reg) && (fin_a_reg <= fin_e_reg);
        end
        else
        begin
            inside_next = !((fin_a_reg > fin_e_reg) && (fin_a_reg < fin_s_reg));
        end
        all_next    = run_ok_reg && inside_next;
        run_ok_next = run_ok_reg;
        if (load_out)
        begin
            run_ok_next = fin_last_reg ? 1'b1 : all_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            run_ok_reg    <= 1'b1;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
            run_ok_reg    <= run_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            wrapped_reg <= fin_a_reg;
            inside_reg  <= inside_next;
            all_reg     <= all_next;
            run_end_reg <= fin_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign wrapped_angle   = wrapped_reg;
    assign angle_in_region = inside_reg;
    assign all_in_region   = all_reg;
    assign run_end         = run_end_reg;

    a_wrapped_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (wrapped_reg < awac_pkg::TWO_PI))
        else $error("wrapped angle not below 2pi");

    a_all_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && all_reg |-> inside_reg)
        else $error("run verdict set on an outside angle");

    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && fin_last_reg |=> run_ok_reg)
        else $error("run state not restored after last");

    a_snap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (wrapped_reg != '0) |-> (wrapped_reg >= tol))
        else $error("wrapped angle inside zero tolerance not snapped");

endmodule

// File: rtl/angle_wrap_and_arc_check.sv
// ----------------------------------------------------------------------------
// angle_wrap_and_arc_check - wrap Q7.24 angles into [0, 2pi) and test an arc
// Sign split, a chain of five conditional-subtract cells, then fix-up, snap,
// arc containment and a running all-inside verdict per run.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | angle[31:0] signed, last
//  output  | out_valid / out_stall| wrapped_angle[26:0], angle_in_region,
//          |                      | all_in_region, run_end
//  config  | wr_en                | wr_index[1:0], wr_data[31:0]
//
// one transfer per cycle sustained while out_stall is low; the registered
// stages are entry, five cells, finish and output register
// reset clears all stage valids and restores the run verdict to all-inside
// an output stall holds every full stage at once, not one stage at a time
// ----------------------------------------------------------------------------
module angle_wrap_and_arc_check
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [awac_pkg::ANGLE_W-1:0] angle,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [awac_pkg::RES_W-1:0]   wrapped_angle,
    output logic                         angle_in_region,
    output logic                         all_in_region,
    output logic                         run_end,
    input  logic                         wr_en,
    input  logic [awac_pkg::IDX_W-1:0]   wr_index,
    input  logic [awac_pkg::ANGLE_W-1:0] wr_data
);

    logic [awac_pkg::ANGLE_W-1:0] start_reg;
    logic [awac_pkg::ANGLE_W-1:0] end_reg;
    logic [awac_pkg::TOL_W-1:0]   tol_reg;

    // entry stage
    logic            ent_valid_reg;
    logic            ent_valid_next;
    logic            ent_ready;
    awac_pkg::lane_t ent_lane_reg;
    awac_pkg::lane_t ent_lane_next;

    logic            chain_valid [awac_pkg::N_CELLS+1];
    logic            chain_ready [awac_pkg::N_CELLS+1];
    awac_pkg::lane_t chain_lane  [awac_pkg::N_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            tol_reg   <= awac_pkg::TOL_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                awac_pkg::REG_REGION_START:   start_reg <= wr_data;
                awac_pkg::REG_REGION_END:     end_reg   <= wr_data;
                awac_pkg::REG_ZERO_TOLERANCE: tol_reg   <= wr_data[awac_pkg::TOL_W-1:0];
                default:                      ;
            endcase
        end
    end

    // split into sign and magnitude; the most negative value becomes 2^31
    always_comb
    begin
        ent_lane_next.a_neg = angle[awac_pkg::ANGLE_W-1];
        ent_lane_next.s_neg = start_reg[awac_pkg::ANGLE_W-1];
        ent_lane_next.e_neg = end_reg[awac_pkg::ANGLE_W-1];
        ent_lane_next.a_mag = ent_lane_next.a_neg ? (~angle + 1'b1) : angle;
        ent_lane_next.s_mag = ent_lane_next.s_neg ? (~start_reg + 1'b1) : start_reg;
        ent_lane_next.e_mag = ent_lane_next.e_neg ? (~end_reg + 1'b1) : end_reg;
        ent_lane_next.last  = last;
    end

    assign ent_ready      = !ent_valid_reg || chain_ready[0];
    assign in_stall       = !ent_ready;
    assign ent_valid_next = ent_ready ? in_valid : ent_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_ready && in_valid)
        begin
            ent_lane_reg <= ent_lane_next;
        end
    end

    assign chain_valid[0] = ent_valid_reg;
    assign chain_lane[0]  = ent_lane_reg;

    for (genvar i = 0; i < awac_pkg::N_CELLS; i++)
    begin : g_cell
        awac_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .mult      (awac_pkg::cell_mult(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_lane   (chain_lane[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_lane  (chain_lane[i+1])
        );
    end

    awac_tail u_tail
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .tol             (tol_reg),
        .in_valid        (chain_valid[awac_pkg::N_CELLS]),
        .in_ready        (chain_ready[awac_pkg::N_CELLS]),
        .in_lane         (chain_lane[awac_pkg::N_CELLS]),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wrapped_angle   (wrapped_angle),
        .angle_in_region (angle_in_region),
        .all_in_region   (all_in_region),
        .run_end         (run_end)
    );

endmodule
